@@ sv/fisd_pkg.sv @@
// Package for the fast inverse square root unit: constants, stage types and stage functions.
`default_nettype none
package fisd_pkg;

  localparam int ITERATIONS_DEF = 2;

  localparam logic [63:0] MAGIC = 64'h5FE6EB50C7B537AA;
  localparam logic [63:0] QNAN  = 64'h7FF8000000000000;
  localparam logic [63:0] PINF  = 64'h7FF0000000000000;

  // Mantissa of 1.5 with the hidden bit at position 52.
  localparam logic [52:0] ONE_HALF_MANT = 53'h18000000000000;

  // Register stages of one multiply, of the subtract, and of one Newton step.
  localparam int MUL_LAT  = 5;
  localparam int SUB_LAT  = 5;
  localparam int ITER_LAT = 3 * MUL_LAT + SUB_LAT;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [12:0] e;
    logic [52:0]        m;
  } fp_unp_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [12:0] esum;
    logic [52:0]        ma;
    logic [52:0]        mb;
  } fmul_s1_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [12:0] esum;
    logic [53:0]        hh;
    logic [52:0]        hl;
    logic [52:0]        lh;
    logic [51:0]        ll;
  } fmul_s2_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [12:0] esum;
    logic [105:0]       p;
  } fmul_s3_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic        ovf;
    logic [62:0] pre;
    logic        g;
    logic        s;
  } fmul_s4_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sub;
    logic               sign;
    logic signed [12:0] e;
    logic [52:0]        mb;
    logic [52:0]        ms;
    logic [5:0]         d;
  } fsub_s1_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               sub;
    logic               sign;
    logic signed [12:0] e;
    logic [55:0]        mb;
    logic [55:0]        ms;
  } fsub_s2_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [12:0] e;
    logic [55:0]        n;
  } fsub_s3_t;

  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) n = 6'(52 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc56(input logic [55:0] m);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (m[i]) n = 6'(55 - i);
    end
    return n;
  endfunction

  // Subnormal operands come out normalized, with an exponent below -1022.
  function automatic fp_unp_t fp_unpack(input logic [63:0] b);
    fp_unp_t    u;
    logic [5:0] lz;
    u.sign = b[63];
    u.nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    u.inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    u.zero = (b[62:0] == 63'd0);
    if (b[62:52] == 11'd0) begin
      lz  = lzc53({1'b0, b[51:0]});
      u.m = {1'b0, b[51:0]} << lz;
      u.e = -13'sd1022 - $signed({7'b0, lz});
    end else begin
      lz  = 6'd0;
      u.m = {1'b1, b[51:0]};
      u.e = $signed({2'b0, b[62:52]}) - 13'sd1023;
    end
    return u;
  endfunction

  function automatic fmul_s1_t fmul_unpack(input logic [63:0] a, input logic [63:0] b);
    fp_unp_t  ua;
    fp_unp_t  ub;
    fmul_s1_t o;
    ua     = fp_unpack(a);
    ub     = fp_unpack(b);
    o.sign = ua.sign ^ ub.sign;
    o.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    o.inf  = ua.inf | ub.inf;
    o.zero = ua.zero | ub.zero;
    o.esum = ua.e + ub.e;
    o.ma   = ua.m;
    o.mb   = ub.m;
    return o;
  endfunction

  function automatic fmul_s2_t fmul_pp(input fmul_s1_t s);
    fmul_s2_t o;
    o.sign = s.sign;
    o.nan  = s.nan;
    o.inf  = s.inf;
    o.zero = s.zero;
    o.esum = s.esum;
    o.hh   = s.ma[52:26] * s.mb[52:26];
    o.hl   = s.ma[52:26] * s.mb[25:0];
    o.lh   = s.ma[25:0] * s.mb[52:26];
    o.ll   = s.ma[25:0] * s.mb[25:0];
    return o;
  endfunction

  function automatic fmul_s3_t fmul_sum(input fmul_s2_t s);
    fmul_s3_t o;
    o.sign = s.sign;
    o.nan  = s.nan;
    o.inf  = s.inf;
    o.zero = s.zero;
    o.esum = s.esum;
    o.p    = (106'(s.hh) << 52) + ((106'(s.hl) + 106'(s.lh)) << 26) + 106'(s.ll);
    return o;
  endfunction

  function automatic fmul_s4_t fmul_norm(input fmul_s3_t s);
    fmul_s4_t           o;
    logic [105:0]       r;
    logic [105:0]       sh;
    logic [105:0]       lost;
    logic signed [12:0] e;
    logic signed [12:0] eb;
    logic signed [12:0] dfull;
    logic [6:0]         dd;
    o.sign = s.sign;
    o.nan  = s.nan;
    o.inf  = s.inf;
    o.zero = s.zero;
    o.ovf  = 1'b0;
    o.pre  = 63'd0;
    o.g    = 1'b0;
    o.s    = 1'b0;
    r      = s.p[105] ? s.p : (s.p << 1);
    e      = s.esum + $signed({12'b0, s.p[105]});
    eb     = e + 13'sd1023;
    dfull  = -13'sd1022 - e;
    dd     = (dfull > 13'sd106) ? 7'd106 : dfull[6:0];
    {sh, lost} = {r, 106'b0} >> dd;
    if (e > 13'sd1023) begin
      o.ovf = 1'b1;
    end else if (e >= -13'sd1022) begin
      o.pre = {eb[10:0], r[104:53]};
      o.g   = r[52];
      o.s   = |r[51:0];
    end else begin
      // Gradual underflow: the value is shifted into the subnormal range.
      o.pre = {11'b0, sh[104:53]};
      o.g   = sh[52];
      o.s   = (|sh[51:0]) | (|lost);
    end
    return o;
  endfunction

  function automatic logic [63:0] fmul_round(input fmul_s4_t s);
    logic        inc;
    logic [62:0] mag;
    logic [63:0] r;
    inc = s.g & (s.s | s.pre[0]);
    mag = s.pre + 63'(inc);
    if (s.nan) begin
      r = QNAN;
    end else if (s.inf || s.ovf) begin
      r = {s.sign, PINF[62:0]};
    end else if (s.zero) begin
      r = {s.sign, 63'd0};
    end else begin
      r = {s.sign, mag};
    end
    return r;
  endfunction

  // First subtract stage: order the operands of 1.5 - u by magnitude.
  function automatic fsub_s1_t fsub_prep(input logic [63:0] u);
    fp_unp_t            uu;
    fsub_s1_t           o;
    logic               ubig;
    logic signed [12:0] dfull;
    uu    = fp_unpack(u);
    ubig  = (uu.e > 13'sd0) || ((uu.e == 13'sd0) && (uu.m > ONE_HALF_MANT));
    dfull = ubig ? uu.e : -uu.e;
    o.nan = uu.nan;
    o.inf = uu.inf;
    o.sub = ~uu.sign;
    o.sign = uu.inf ? ~uu.sign : (~uu.sign & ubig);
    o.e   = ubig ? uu.e : 13'sd0;
    o.mb  = ubig ? uu.m : ONE_HALF_MANT;
    o.ms  = ubig ? ONE_HALF_MANT : uu.m;
    o.d   = (dfull > 13'sd63) ? 6'd63 : dfull[5:0];
    return o;
  endfunction

  function automatic fsub_s2_t fsub_align(input fsub_s1_t s);
    fsub_s2_t    o;
    logic [55:0] sh;
    logic [63:0] lost;
    {sh, lost} = {s.ms, 3'b0, 64'b0} >> s.d;
    o.nan  = s.nan;
    o.inf  = s.inf;
    o.sub  = s.sub;
    o.sign = s.sign;
    o.e    = s.e;
    o.mb   = {s.mb, 3'b0};
    o.ms   = {sh[55:1], sh[0] | (|lost)};
    return o;
  endfunction

  function automatic fsub_s3_t fsub_add(input fsub_s2_t s);
    fsub_s3_t    o;
    logic [56:0] sum;
    sum    = {1'b0, s.mb} + {1'b0, s.ms};
    o.nan  = s.nan;
    o.inf  = s.inf;
    o.zero = 1'b0;
    o.sign = s.sign;
    o.e    = s.e;
    if (s.sub) begin
      o.n = s.mb - s.ms;
    end else if (sum[56]) begin
      o.n = {sum[56:2], sum[1] | sum[0]};
      o.e = s.e + 13'sd1;
    end else begin
      o.n = sum[55:0];
    end
    return o;
  endfunction

  function automatic fsub_s3_t fsub_norm(input fsub_s3_t s);
    fsub_s3_t   o;
    logic [5:0] lz;
    lz     = lzc56(s.n);
    o      = s;
    o.zero = (s.n == 56'd0);
    o.n    = s.n << lz;
    o.e    = s.e - $signed({7'b0, lz});
    return o;
  endfunction

  function automatic logic [63:0] fsub_round(input fsub_s3_t s);
    logic               inc;
    logic signed [12:0] eb;
    logic [62:0]        mag;
    logic [63:0]        r;
    inc = s.n[2] & ((|s.n[1:0]) | s.n[3]);
    eb  = s.e + 13'sd1023;
    mag = {eb[10:0], s.n[54:3]} + 63'(inc);
    if (s.nan) begin
      r = QNAN;
    end else if (s.inf || (s.e > 13'sd1023)) begin
      r = {s.sign, PINF[62:0]};
    end else if (s.zero) begin
      r = 64'd0;
    end else begin
      r = {s.sign, mag};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/fisd_newton.sv @@
// One pipelined Newton step y * (1.5 - ((x/2) * y) * y) in binary64.
`default_nettype none
module fisd_newton (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] half_in,
  input  wire logic [63:0] y_in,
  output logic      [63:0] half_out,
  output logic      [63:0] y_out
);

  localparam int NMUL    = 3;
  localparam int YTAP_U  = fisd_pkg::MUL_LAT - 1;
  localparam int YTAP_Y  = 2 * fisd_pkg::MUL_LAT + fisd_pkg::SUB_LAT - 1;
  localparam int HDEPTH  = fisd_pkg::ITER_LAT;

  fisd_pkg::fmul_s1_t m1 [NMUL];
  fisd_pkg::fmul_s2_t m2 [NMUL];
  fisd_pkg::fmul_s3_t m3 [NMUL];
  fisd_pkg::fmul_s4_t m4 [NMUL];
  logic [63:0]        mul_r [NMUL];
  logic [63:0]        mul_a [NMUL];
  logic [63:0]        mul_b [NMUL];

  fisd_pkg::fsub_s1_t s1;
  fisd_pkg::fsub_s2_t s2;
  fisd_pkg::fsub_s3_t s3;
  fisd_pkg::fsub_s3_t s4;
  logic [63:0]        corr;

  logic [63:0] y_dly [YTAP_Y + 1];
  logic [63:0] h_dly [HDEPTH];

  // Multiplier 0 forms t, multiplier 1 forms u, multiplier 2 the new y.
  always_comb begin
    mul_a[0] = half_in;
    mul_b[0] = y_in;
    mul_a[1] = mul_r[0];
    mul_b[1] = y_dly[YTAP_U];
    mul_a[2] = y_dly[YTAP_Y];
    mul_b[2] = corr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NMUL; k++) begin
        m1[k]    <= fisd_pkg::fmul_unpack(mul_a[k], mul_b[k]);
        m2[k]    <= fisd_pkg::fmul_pp(m1[k]);
        m3[k]    <= fisd_pkg::fmul_sum(m2[k]);
        m4[k]    <= fisd_pkg::fmul_norm(m3[k]);
        mul_r[k] <= fisd_pkg::fmul_round(m4[k]);
      end
      s1   <= fisd_pkg::fsub_prep(mul_r[1]);
      s2   <= fisd_pkg::fsub_align(s1);
      s3   <= fisd_pkg::fsub_add(s2);
      s4   <= fisd_pkg::fsub_norm(s3);
      corr <= fisd_pkg::fsub_round(s4);
      y_dly[0] <= y_in;
      for (int i = 1; i <= YTAP_Y; i++) begin
        y_dly[i] <= y_dly[i - 1];
      end
      h_dly[0] <= half_in;
      for (int i = 1; i < HDEPTH; i++) begin
        h_dly[i] <= h_dly[i - 1];
      end
    end
  end

  assign y_out    = mul_r[2];
  assign half_out = h_dly[HDEPTH - 1];

endmodule
`default_nettype wire

@@ sv/fast_inverse_sqrt_double.sv @@
// Top level of the pipelined binary64 fast inverse square root unit.
`default_nettype none
// Takes one binary64 bit pattern per cycle and returns an approximation of
// 1/sqrt(x): the magic-constant guess refined by ITERATIONS Newton steps, each
// operation rounded to nearest even as a separate multiply or subtract, with
// gradual underflow. Negative nonzero inputs and NaN give quiet NaN, zero
// gives +inf, +inf gives +0. The pipeline is an entry stage, twenty stages per
// Newton step (three five-stage multipliers and a five-stage subtract in
// series) and an output register. A new operand is taken every cycle; when
// the output is stalled the whole pipeline holds.
module fast_inverse_sqrt_double #(
  parameter int ITERATIONS = fisd_pkg::ITERATIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        operand_valid,
  output logic             operand_stall,
  input  wire logic [63:0] operand_bits,
  output logic             rsqrt_valid,
  input  wire logic        rsqrt_stall,
  output logic      [63:0] rsqrt_bits
);

  localparam int D = ITERATIONS * fisd_pkg::ITER_LAT;

  logic        en;
  logic [D:0]  valid_line;
  logic [D:0]  spec_line;
  logic [63:0] specv_line [D + 1];
  logic [63:0] half_c [ITERATIONS + 1];
  logic [63:0] y_c [ITERATIONS + 1];

  logic        spec_next;
  logic [63:0] specv_next;
  logic [63:0] half_next;
  logic [52:0] sub_m;
  logic        half_inc;

  assign en            = !rsqrt_valid || !rsqrt_stall;
  assign operand_stall = !en;

  always_comb begin
    spec_next  = 1'b1;
    specv_next = 64'd0;
    if (operand_bits[62:0] > fisd_pkg::PINF[62:0]) begin
      specv_next = fisd_pkg::QNAN;
    end else if (operand_bits[63] && (operand_bits[62:0] != 63'd0)) begin
      specv_next = fisd_pkg::QNAN;
    end else if (operand_bits[62:0] == 63'd0) begin
      specv_next = fisd_pkg::PINF;
    end else if (operand_bits[62:0] == fisd_pkg::PINF[62:0]) begin
      specv_next = 64'd0;
    end else begin
      spec_next = 1'b0;
    end
  end

  // Halving is an exponent decrement, except near the bottom of the range
  // where the mantissa shifts right and rounds to even.
  always_comb begin
    sub_m    = {operand_bits[62:52] == 11'd1, operand_bits[51:0]};
    half_inc = sub_m[0] & sub_m[1];
    if (operand_bits[62:52] >= 11'd2) begin
      half_next = {1'b0, operand_bits[62:52] - 11'd1, operand_bits[51:0]};
    end else begin
      half_next = {1'b0, {11'b0, sub_m[52:1]} + 63'(half_inc)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_line  <= '0;
      rsqrt_valid <= 1'b0;
    end else if (en) begin
      valid_line[0] <= operand_valid;
      for (int i = 1; i <= D; i++) begin
        valid_line[i] <= valid_line[i - 1];
      end
      rsqrt_valid <= valid_line[D];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec_line[0]  <= spec_next;
      specv_line[0] <= specv_next;
      half_c[0]     <= half_next;
      y_c[0]        <= fisd_pkg::MAGIC - (operand_bits >> 1);
      for (int i = 1; i <= D; i++) begin
        spec_line[i]  <= spec_line[i - 1];
        specv_line[i] <= specv_line[i - 1];
      end
      rsqrt_bits <= spec_line[D] ? specv_line[D] : y_c[ITERATIONS];
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
    fisd_newton u_newton (
      .clk      (clk),
      .en       (en),
      .half_in  (half_c[k]),
      .y_in     (y_c[k]),
      .half_out (half_c[k + 1]),
      .y_out    (y_c[k + 1])
    );
  end

endmodule
`default_nettype wire
